FILE: src/tbs_pkg.sv
// Shared constants and types for the temperature band statistics block.
// Holds field widths, saturation limits, reset thresholds, register indexes and class codes.
// No dependencies.
`timescale 1ns / 1ps

package tbs_pkg;

	localparam int MAX_SAMPLES = 4096;

	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 15;
	localparam int CNT_W    = 13;
	localparam int VALID_W  = 15;
	localparam int SUM_W    = 28;
	localparam int POS_W    = 12;
	localparam int CLS_W    = 3;
	localparam int IDX_W    = 2;
	localparam int DATA_W   = 128;
	localparam int USER_W   = 4;

	localparam int COUNT_CAP_I = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;
	localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(COUNT_CAP_I);
	localparam logic [SUM_W-1:0] SUM_CAP   = {SUM_W{1'b1}};
	localparam logic [POS_W-1:0] POS_CAP   = {POS_W{1'b1}};
	localparam logic [THR_W-1:0] AVG_CAP   = {THR_W{1'b1}};

	localparam logic [THR_W-1:0] WARNING_RESET  = 15'd480;
	localparam logic [THR_W-1:0] CRITICAL_RESET = 15'd720;
	localparam logic [THR_W-1:0] SHUTDOWN_RESET = 15'd960;

	localparam logic [IDX_W-1:0] REG_WARNING  = 2'd0;
	localparam logic [IDX_W-1:0] REG_CRITICAL = 2'd1;
	localparam logic [IDX_W-1:0] REG_SHUTDOWN = 2'd2;

	typedef enum logic [CLS_W-1:0] {
		CLS_NORMAL   = 3'd0,
		CLS_WARNING  = 3'd1,
		CLS_CRITICAL = 3'd2,
		CLS_SHUTDOWN = 3'd3,
		CLS_SKIPPED  = 3'd4
	} class_t;

endpackage

FILE: src/temperature_band_statistics.sv
// Temperature band statistics: classifies Q11.4 samples into bands and keeps batch statistics.
// Uses tbs_pkg for widths, limits, register indexes and class codes.
// A valid sample passes through the compare steps, the accumulate step and the emit step; an
// error sample skips the compares. The last sample of a batch with valid data also runs the restoring divider.
// A new sample is accepted only once the previous result is emitted; the five threshold and
// min/max compares share one comparator, and the average reuses one subtractor per cycle.
// Reset (arst_n low) clears all statistics and loads the default thresholds 30, 45 and 60 degrees.
`timescale 1ns / 1ps

module temperature_band_statistics (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tbs_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
	input  logic                          s_tlast,   // last_sample
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [12:0] normal_count, [25:13] warning_count, [38:26] critical_count,
	// [51:39] shutdown_count, [64:52] skipped_count, [79:65] lowest_valid,
	// [94:80] highest_valid, [109:95] average_valid, [121:110] first_critical_index,
	// [127:122] zero
	output logic [tbs_pkg::DATA_W-1:0]    m_tdata,
	output logic [tbs_pkg::USER_W-1:0]    m_tuser,   // [2:0] sample_class, [3] critical_seen
	output logic                          m_tlast,   // summary_ready
	// Threshold register writes.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tbs_pkg::IDX_W-1:0]     cfg_index,
	input  logic [tbs_pkg::THR_W-1:0]     cfg_data
);

	// The sequencer walks each item through compare steps (not for error samples), one accumulate step,
	// an optional divide loop and an emit step that waits for the output register.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SUM,
		ST_DIV,
		ST_EMIT
	} state_t;

	localparam logic [2:0] STEP_SHUT = 3'd0;
	localparam logic [2:0] STEP_CRIT = 3'd1;
	localparam logic [2:0] STEP_WARN = 3'd2;
	localparam logic [2:0] STEP_MIN  = 3'd3;
	localparam logic [2:0] STEP_MAX  = 3'd4;
	localparam logic [4:0] DIV_LAST  = 5'(tbs_pkg::SUM_W - 1);
	localparam int VALID_W_SUM = tbs_pkg::VALID_W;

	state_t state_q;
	logic [2:0] step_q;
	logic [4:0] div_cnt_q;

	// Configuration registers.
	logic [tbs_pkg::THR_W-1:0] warn_thr_q, crit_thr_q, shut_thr_q;

	// Current item and compare results.
	logic [tbs_pkg::SAMPLE_W-1:0] sample_q;
	logic last_q;
	logic ge_shut_q, ge_crit_q, ge_warn_q, lt_min_q, gt_max_q;

	// Batch statistics.
	logic [tbs_pkg::CNT_W-1:0]   normal_q, warning_q, critical_q, shutdown_q, error_q;
	logic [tbs_pkg::VALID_W-1:0] valid_cnt_q;
	logic [tbs_pkg::SUM_W-1:0]   sum_q;
	logic [tbs_pkg::THR_W-1:0]   min_q, max_q;
	logic [tbs_pkg::POS_W-1:0]   hot_pos_q, pos_q;
	logic hot_found_q;

	// Divider: dividend shifts out the top while quotient bits shift in below.
	logic [tbs_pkg::SUM_W-1:0]   quo_q;
	logic [tbs_pkg::VALID_W-1:0] rem_q;

	// Output register.
	logic m_tvalid_q;
	logic [tbs_pkg::DATA_W-1:0] m_tdata_q;
	logic [tbs_pkg::USER_W-1:0] m_tuser_q;
	logic m_tlast_q;

	// Shared comparator: cmp_a >= cmp_b, operands picked by the compare step.
	logic [tbs_pkg::SAMPLE_W-1:0] cmp_a, cmp_b;
	logic cmp_ge;

	always_comb begin
		cmp_a = sample_q;
		cmp_b = {1'b0, shut_thr_q};
		case (step_q)
			STEP_SHUT: cmp_b = {1'b0, shut_thr_q};
			STEP_CRIT: cmp_b = {1'b0, crit_thr_q};
			STEP_WARN: cmp_b = {1'b0, warn_thr_q};
			STEP_MIN:  cmp_b = {1'b0, min_q};
			STEP_MAX: begin
				cmp_a = {1'b0, max_q};
				cmp_b = sample_q;
			end
			default:   cmp_b = {1'b0, shut_thr_q};
		endcase
	end

	assign cmp_ge = (cmp_a >= cmp_b);

	// Accumulate step helpers.
	logic is_err;
	tbs_pkg::class_t cls;
	logic [tbs_pkg::SUM_W:0] sum_wide;
	logic [tbs_pkg::SUM_W-1:0] sum_next;

	assign is_err = sample_q[tbs_pkg::SAMPLE_W-1];
	assign sum_wide = {1'b0, sum_q} + (tbs_pkg::SUM_W+1)'(sample_q[tbs_pkg::THR_W-1:0]);
	assign sum_next = sum_wide[tbs_pkg::SUM_W] ? tbs_pkg::SUM_CAP : sum_wide[tbs_pkg::SUM_W-1:0];

	always_comb begin
		if (is_err) begin
			cls = tbs_pkg::CLS_SKIPPED;
		end else if (ge_shut_q) begin
			cls = tbs_pkg::CLS_SHUTDOWN;
		end else if (ge_crit_q) begin
			cls = tbs_pkg::CLS_CRITICAL;
		end else if (ge_warn_q) begin
			cls = tbs_pkg::CLS_WARNING;
		end else begin
			cls = tbs_pkg::CLS_NORMAL;
		end
	end

	// One restoring divide step.
	logic [tbs_pkg::VALID_W:0] trial;
	logic [tbs_pkg::VALID_W:0] trial_sub;
	logic trial_ok;

	assign trial     = {rem_q, quo_q[tbs_pkg::SUM_W-1]};
	assign trial_sub = trial - {1'b0, valid_cnt_q};
	assign trial_ok  = (trial >= {1'b0, valid_cnt_q});

	// Result word.
	logic out_free;
	logic have_valid;
	logic [tbs_pkg::THR_W-1:0] avg;
	logic [tbs_pkg::DATA_W-1:0] data_next;

	assign out_free   = !m_tvalid_q || m_tready;
	assign have_valid = (valid_cnt_q != '0);

	always_comb begin
		avg = '0;
		if (last_q && have_valid) begin
			avg = (quo_q[tbs_pkg::SUM_W-1:tbs_pkg::THR_W] != '0) ? tbs_pkg::AVG_CAP
				: quo_q[tbs_pkg::THR_W-1:0];
		end
		data_next = {
			6'd0,
			hot_found_q ? hot_pos_q : '0,
			avg,
			have_valid ? max_q : '0,
			have_valid ? min_q : '0,
			error_q,
			shutdown_q,
			critical_q,
			warning_q,
			normal_q
		};
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_thr_q <= tbs_pkg::WARNING_RESET;
			crit_thr_q <= tbs_pkg::CRITICAL_RESET;
			shut_thr_q <= tbs_pkg::SHUTDOWN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tbs_pkg::REG_WARNING:  warn_thr_q <= cfg_data;
				tbs_pkg::REG_CRITICAL: crit_thr_q <= cfg_data;
				tbs_pkg::REG_SHUTDOWN: shut_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, statistics and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			div_cnt_q   <= '0;
			sample_q    <= '0;
			last_q      <= 1'b0;
			ge_shut_q   <= 1'b0;
			ge_crit_q   <= 1'b0;
			ge_warn_q   <= 1'b0;
			lt_min_q    <= 1'b0;
			gt_max_q    <= 1'b0;
			normal_q    <= '0;
			warning_q   <= '0;
			critical_q  <= '0;
			shutdown_q  <= '0;
			error_q     <= '0;
			valid_cnt_q <= '0;
			sum_q       <= '0;
			min_q       <= '1;
			max_q       <= '0;
			hot_pos_q   <= '0;
			hot_found_q <= 1'b0;
			pos_q       <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			m_tuser_q   <= '0;
			m_tlast_q   <= 1'b0;
		end else begin
			// In the emit step the output register is reloaded instead.
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sample_q <= s_tdata;
						last_q   <= s_tlast;
						step_q   <= STEP_SHUT;
						state_q  <= s_tdata[tbs_pkg::SAMPLE_W-1] ? ST_SUM : ST_CMP;
					end
				end
				ST_CMP: begin
					case (step_q)
						STEP_SHUT: ge_shut_q <= cmp_ge;
						STEP_CRIT: ge_crit_q <= cmp_ge;
						STEP_WARN: ge_warn_q <= cmp_ge;
						STEP_MIN:  lt_min_q  <= !cmp_ge;
						STEP_MAX:  gt_max_q  <= !cmp_ge;
						default: ;
					endcase
					step_q <= step_q + 3'd1;
					if (step_q == STEP_MAX) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					case (cls)
						tbs_pkg::CLS_NORMAL: begin
							if (normal_q < tbs_pkg::COUNT_CAP) begin
								normal_q    <= normal_q + 1'b1;
								valid_cnt_q <= valid_cnt_q + 1'b1;
							end
						end
						tbs_pkg::CLS_WARNING: begin
							if (warning_q < tbs_pkg::COUNT_CAP) begin
								warning_q   <= warning_q + 1'b1;
								valid_cnt_q <= valid_cnt_q + 1'b1;
							end
						end
						tbs_pkg::CLS_CRITICAL: begin
							if (critical_q < tbs_pkg::COUNT_CAP) begin
								critical_q  <= critical_q + 1'b1;
								valid_cnt_q <= valid_cnt_q + 1'b1;
							end
						end
						tbs_pkg::CLS_SHUTDOWN: begin
							if (shutdown_q < tbs_pkg::COUNT_CAP) begin
								shutdown_q  <= shutdown_q + 1'b1;
								valid_cnt_q <= valid_cnt_q + 1'b1;
							end
						end
						default: begin
							if (error_q < tbs_pkg::COUNT_CAP) begin
								error_q <= error_q + 1'b1;
							end
						end
					endcase
					if (!is_err) begin
						sum_q <= sum_next;
						if (lt_min_q) begin
							min_q <= sample_q[tbs_pkg::THR_W-1:0];
						end
						if (gt_max_q) begin
							max_q <= sample_q[tbs_pkg::THR_W-1:0];
						end
						if (!hot_found_q && ge_crit_q) begin
							hot_found_q <= 1'b1;
							hot_pos_q   <= pos_q;
						end
					end
					// A valid sample always leaves the valid count nonzero.
					if (last_q && (have_valid || !is_err)) begin
						quo_q     <= is_err ? sum_q : sum_next;
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					rem_q     <= trial_ok ? trial_sub[tbs_pkg::VALID_W-1:0]
						: trial[tbs_pkg::VALID_W-1:0];
					quo_q     <= {quo_q[tbs_pkg::SUM_W-2:0], trial_ok};
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= data_next;
						m_tuser_q  <= {hot_found_q, cls};
						m_tlast_q  <= last_q;
						state_q    <= ST_IDLE;
						if (last_q) begin
							normal_q    <= '0;
							warning_q   <= '0;
							critical_q  <= '0;
							shutdown_q  <= '0;
							error_q     <= '0;
							valid_cnt_q <= '0;
							sum_q       <= '0;
							min_q       <= '1;
							max_q       <= '0;
							hot_pos_q   <= '0;
							hot_found_q <= 1'b0;
							pos_q       <= '0;
						end else if (pos_q < tbs_pkg::POS_CAP) begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// The valid count tracks the sum of the four band tallies.
	a_valid_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		valid_cnt_q == (VALID_W_SUM'(normal_q) + VALID_W_SUM'(warning_q)
			+ VALID_W_SUM'(critical_q) + VALID_W_SUM'(shutdown_q)))
		else $error("valid count out of step with band tallies");

	// A found hot position implies a sample landed in the critical or shutdown band.
	a_hot_band: assert property (@(posedge clk) disable iff (!arst_n)
		hot_found_q |-> (critical_q != '0 || shutdown_q != '0))
		else $error("hot position without critical or shutdown sample");

	// The divider only runs with a nonzero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> have_valid)
		else $error("divide started with no valid samples");

	// Emitting the end of a batch clears the statistics.
	a_batch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && last_q) |=>
			(valid_cnt_q == '0 && error_q == '0 && !hot_found_q && pos_q == '0))
		else $error("statistics not cleared after end of batch");

	// Only a summary result carries an average.
	a_avg_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[109:95] == '0))
		else $error("average reported outside of a summary");

endmodule
